// File: rtl/fcsl_pkg.sv
// fcsl_pkg: shared types, reset values and helper functions for the flight command limiter
// no dependencies; imported by every rtl module of the block except fcsl_checker
package fcsl_pkg;

    localparam logic [14:0] MAX_SPEED_RST = 15'd2560;
    localparam logic [14:0] MAX_TURN_RST  = 15'd4096;
    localparam logic [14:0] MAX_TILT_RST  = 15'd2145;
    localparam logic [23:0] CEILING_RST   = 24'd30720;
    localparam logic [23:0] FLOOR_RST     = 24'd0;

    // x / 10 as (x * 52429) >> 19, exact for x up to 2^15
    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam int SQRT_STAGES = 16;
    localparam int DIV_STAGES  = 15;

    typedef enum logic [2:0] {
        CFG_MAX_SPEED = 3'd0,
        CFG_MAX_TURN  = 3'd1,
        CFG_MAX_TILT  = 3'd2,
        CFG_CEILING   = 3'd3,
        CFG_FLOOR     = 3'd4,
        CFG_ESTOP     = 3'd5
    } cfg_idx_t;

    localparam int VIO_ESTOP   = 0;
    localparam int VIO_SPEED   = 1;
    localparam int VIO_YAW     = 2;
    localparam int VIO_ROLL    = 3;
    localparam int VIO_PITCH   = 4;
    localparam int VIO_CEILING = 5;
    localparam int VIO_FLOOR   = 6;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic signed [15:0] yaw;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [23:0] alt;
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] sum;
    } sum_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] mag;
    } mag_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        ov;
        logic [14:0] qx;
        logic [14:0] qy;
        logic [14:0] qz;
    } scl_t;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic signed [15:0] yaw;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic [6:0]         mask;
        logic               safe;
    } res_t;

    typedef struct packed {
        logic [14:0]        max_speed;
        logic [14:0]        max_turn;
        logic [14:0]        max_tilt;
        logic signed [23:0] ceiling;
        logic signed [23:0] floor_lim;
        logic               estop;
    } cfg_t;

    function automatic logic [16:0] abs17(input logic [15:0] v);
        logic [16:0] e;
        begin
            e = {v[15], v};
            abs17 = v[15] ? (~e + 17'd1) : e;
        end
    endfunction

    function automatic logic exceeds(input logic [15:0] x, input logic [14:0] lim);
        logic signed [16:0] xe;
        logic signed [16:0] le;
        begin
            xe = $signed({x[15], x});
            le = $signed({2'b00, lim});
            exceeds = (xe > le) || (xe < -le);
        end
    endfunction

    function automatic logic [15:0] clamp_to(input logic [15:0] x, input logic [14:0] lim);
        begin
            clamp_to = x[15] ? (~{1'b0, lim} + 16'd1) : {1'b0, lim};
        end
    endfunction

endpackage

// File: rtl/flight_command_safety_limiter_unit.sv
// flight_command_safety_limiter_unit: top level, configuration registers and stage chain
// depends on fcsl_pkg, fcsl_front, fcsl_sqrt_pipe, fcsl_scale_pipe, fcsl_limit_stage
//
// usage:
//   s_* carries one flight command per transaction (velocities, yaw, roll, pitch,
//   current altitude); m_* returns the limited command with its violation mask and
//   a safe flag, one result per command, in order.
//   cfg_we/cfg_addr/cfg_wdata write the limit registers (index 0 max speed, 1 max turn
//   rate, 2 max tilt, 3 ceiling, 4 floor, 5 emergency stop); write only while idle.
//   path from input transaction to output valid: the squared speed stages, the
//   square root stages (one root bit per stage), the scale product stage and the
//   divider stages (one quotient bit per divider stage), then altitude and clamps.
//   throughput: one command per cycle; every stage has its own valid bit and moves
//   on when the stage after it is empty or moving, so bubbles are squeezed out.
//   when the receiver stalls, the output register holds its transaction and the
//   stages behind it keep filling until all are full; then s_tready drops.
//   reset clears every valid bit and loads the register defaults; no clearing pass.
module flight_command_safety_limiter_unit
    import fcsl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd_vx, cmd_vy, cmd_vz, cmd_yaw, cmd_roll, cmd_pitch, cur_alt
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_vx, out_vy, out_vz, out_yaw, out_roll, out_pitch, violation_mask, cmd_safe
    output logic [103:0] m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [23:0]  cfg_wdata
);

    cfg_t cfg_reg;
    cmd_t in_cmd;
    sum_t sum_d;
    mag_t mag_d;
    scl_t scl_d;
    res_t res_d;
    logic sum_v, sum_r, mag_v, mag_r, scl_v, scl_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_speed <= MAX_SPEED_RST;
            cfg_reg.max_turn  <= MAX_TURN_RST;
            cfg_reg.max_tilt  <= MAX_TILT_RST;
            cfg_reg.ceiling   <= CEILING_RST;
            cfg_reg.floor_lim <= FLOOR_RST;
            cfg_reg.estop     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_MAX_SPEED: cfg_reg.max_speed <= cfg_wdata[14:0];
                CFG_MAX_TURN:  cfg_reg.max_turn  <= cfg_wdata[14:0];
                CFG_MAX_TILT:  cfg_reg.max_tilt  <= cfg_wdata[14:0];
                CFG_CEILING:   cfg_reg.ceiling   <= cfg_wdata;
                CFG_FLOOR:     cfg_reg.floor_lim <= cfg_wdata;
                CFG_ESTOP:     cfg_reg.estop     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign in_cmd.vx    = s_tdata[15:0];
    assign in_cmd.vy    = s_tdata[31:16];
    assign in_cmd.vz    = s_tdata[47:32];
    assign in_cmd.yaw   = s_tdata[63:48];
    assign in_cmd.roll  = s_tdata[79:64];
    assign in_cmd.pitch = s_tdata[95:80];
    assign in_cmd.alt   = s_tdata[119:96];

    fcsl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .out_valid (sum_v),
        .out_ready (sum_r),
        .out_data  (sum_d)
    );

    fcsl_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_v),
        .in_ready  (sum_r),
        .in_data   (sum_d),
        .out_valid (mag_v),
        .out_ready (mag_r),
        .out_data  (mag_d)
    );

    fcsl_scale_pipe u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_speed (cfg_reg.max_speed),
        .in_valid  (mag_v),
        .in_ready  (mag_r),
        .in_data   (mag_d),
        .out_valid (scl_v),
        .out_ready (scl_r),
        .out_data  (scl_d)
    );

    fcsl_limit_stage u_limit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (scl_v),
        .in_ready  (scl_r),
        .in_data   (scl_d),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_d)
    );

    assign m_tdata = {res_d.safe, res_d.mask, res_d.pitch, res_d.roll,
                      res_d.yaw, res_d.vz, res_d.vy, res_d.vx};

endmodule

// File: rtl/fcsl_front.sv
// fcsl_front: input register, per-axis squares and the squared speed sum (3 stages)
// depends on fcsl_pkg
module fcsl_front
    import fcsl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output sum_t out_data
);

    logic        v0_reg, v1_reg, v2_reg;
    cmd_t        c0_reg, c1_reg, c2_reg;
    logic [30:0] sqx_reg, sqy_reg, sqz_reg;
    logic [31:0] sum_reg;
    logic        adv0, adv1, adv2;
    logic signed [31:0] px, py, pz;

    assign adv2 = ~v2_reg | out_ready;
    assign adv1 = ~v1_reg | adv2;
    assign adv0 = ~v0_reg | adv1;
    assign in_ready = adv0;

    always_comb
    begin
        px = c0_reg.vx * c0_reg.vx;
        py = c0_reg.vy * c0_reg.vy;
        pz = c0_reg.vz * c0_reg.vz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv0) v0_reg <= in_valid;
            if (adv1) v1_reg <= v0_reg;
            if (adv2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv0) c0_reg <= in_cmd;
        if (adv1)
        begin
            c1_reg  <= c0_reg;
            sqx_reg <= px[30:0];
            sqy_reg <= py[30:0];
            sqz_reg <= pz[30:0];
        end
        if (adv2)
        begin
            c2_reg  <= c1_reg;
            sum_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg} + {1'b0, sqz_reg};
        end
    end

    assign out_valid    = v2_reg;
    assign out_data.cmd = c2_reg;
    assign out_data.sum = sum_reg;

endmodule

// File: rtl/fcsl_sqrt_pipe.sv
// fcsl_sqrt_pipe: pipelined integer square root, one result bit per stage
// depends on fcsl_pkg
module fcsl_sqrt_pipe
    import fcsl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sum_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output mag_t out_data
);

    logic [SQRT_STAGES-1:0] vld_reg;
    logic [SQRT_STAGES:0]   adv;
    cmd_t        cmd_reg  [SQRT_STAGES];
    logic [17:0] rem_reg  [SQRT_STAGES];
    logic [15:0] root_reg [SQRT_STAGES];
    logic [31:0] src_reg  [SQRT_STAGES];

    assign adv[SQRT_STAGES] = out_ready;
    assign in_ready = adv[0];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++)
        begin : g_stage
            logic        vin;
            cmd_t        cin;
            logic [17:0] rin;
            logic [15:0] qin;
            logic [31:0] sin;
            logic [19:0] t;
            logic [19:0] trial;
            logic [17:0] rem_next;
            logic [15:0] root_next;

            assign adv[k] = ~vld_reg[k] | adv[k+1];

            if (k == 0)
            begin : g_first
                assign vin = in_valid;
                assign cin = in_data.cmd;
                assign rin = '0;
                assign qin = '0;
                assign sin = in_data.sum;
            end
            else
            begin : g_rest
                assign vin = vld_reg[k-1];
                assign cin = cmd_reg[k-1];
                assign rin = rem_reg[k-1];
                assign qin = root_reg[k-1];
                assign sin = src_reg[k-1];
            end

            always_comb
            begin
                t     = {rin, sin[31:30]};
                trial = {2'b00, qin, 2'b01};
                if (t >= trial)
                begin
                    rem_next  = 18'(t - trial);
                    root_next = {qin[14:0], 1'b1};
                end
                else
                begin
                    rem_next  = t[17:0];
                    root_next = {qin[14:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (adv[k])
                    vld_reg[k] <= vin;
            end

            always_ff @(posedge clk)
            begin
                if (adv[k])
                begin
                    cmd_reg[k]  <= cin;
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    src_reg[k]  <= {sin[29:0], 2'b00};
                end
            end
        end
    endgenerate

    assign out_valid    = vld_reg[SQRT_STAGES-1];
    assign out_data.cmd = cmd_reg[SQRT_STAGES-1];
    assign out_data.mag = root_reg[SQRT_STAGES-1];

endmodule

// File: rtl/fcsl_scale_pipe.sv
// fcsl_scale_pipe: speed check, |v| * max_speed products and three pipelined dividers by mag
// depends on fcsl_pkg
module fcsl_scale_pipe
    import fcsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [14:0] max_speed,
    input  logic        in_valid,
    output logic        in_ready,
    input  mag_t        in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output scl_t        out_data
);

    // stage 0: products; stages 1..DIV_STAGES: one quotient bit each
    localparam int N = DIV_STAGES + 1;

    logic [N-1:0] vld_reg;
    logic [N:0]   adv;
    cmd_t         cmd_reg [N];
    logic         ov_reg  [N];
    logic [15:0]  mag_reg [N];
    logic [15:0]  rem_reg [N][3];
    logic [14:0]  src_reg [N][3];
    logic [14:0]  q_reg   [N][3];

    logic [31:0]  prod [3];
    logic [15:0]  vin_lane [3];

    assign adv[N]   = out_ready;
    assign in_ready = adv[0];

    assign vin_lane[0] = in_data.cmd.vx;
    assign vin_lane[1] = in_data.cmd.vy;
    assign vin_lane[2] = in_data.cmd.vz;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            prod[l] = abs17(vin_lane[l]) * max_speed;
    end

    assign adv[0] = ~vld_reg[0] | adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv[0])
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            cmd_reg[0] <= in_data.cmd;
            ov_reg[0]  <= in_data.mag > {1'b0, max_speed};
            mag_reg[0] <= in_data.mag;
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[0][l] <= prod[l][30:15];
                src_reg[0][l] <= prod[l][14:0];
                q_reg[0][l]   <= '0;
            end
        end
    end

    genvar k;
    generate
        for (k = 1; k < N; k++)
        begin : g_div
            logic [16:0] t        [3];
            logic [15:0] rem_next [3];
            logic [14:0] q_next   [3];

            assign adv[k] = ~vld_reg[k] | adv[k+1];

            always_comb
            begin
                for (int l = 0; l < 3; l++)
                begin
                    t[l] = {rem_reg[k-1][l], src_reg[k-1][l][14]};
                    if (t[l] >= {1'b0, mag_reg[k-1]})
                    begin
                        rem_next[l] = 16'(t[l] - {1'b0, mag_reg[k-1]});
                        q_next[l]   = {q_reg[k-1][l][13:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l] = t[l][15:0];
                        q_next[l]   = {q_reg[k-1][l][13:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (adv[k])
                    vld_reg[k] <= vld_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                if (adv[k])
                begin
                    cmd_reg[k] <= cmd_reg[k-1];
                    ov_reg[k]  <= ov_reg[k-1];
                    mag_reg[k] <= mag_reg[k-1];
                    for (int l = 0; l < 3; l++)
                    begin
                        rem_reg[k][l] <= rem_next[l];
                        src_reg[k][l] <= {src_reg[k-1][l][13:0], 1'b0};
                        q_reg[k][l]   <= q_next[l];
                    end
                end
            end
        end
    endgenerate

    assign out_valid    = vld_reg[N-1];
    assign out_data.cmd = cmd_reg[N-1];
    assign out_data.ov  = ov_reg[N-1];
    assign out_data.qx  = q_reg[N-1][0];
    assign out_data.qy  = q_reg[N-1][1];
    assign out_data.qz  = q_reg[N-1][2];

endmodule

// File: rtl/fcsl_limit_stage.sv
// fcsl_limit_stage: applies scaling, altitude prediction, clamps and emergency stop (2 stages)
// depends on fcsl_pkg; the second register is the block's output register
module fcsl_limit_stage
    import fcsl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic in_valid,
    output logic in_ready,
    input  scl_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);

    logic        va_reg, vb_reg;
    logic        adva, advb;
    cmd_t        ca_reg;
    logic        ova_reg;
    logic signed [15:0] sx_reg, sy_reg, sz_reg;
    logic [11:0] q10_reg;
    res_t        res_reg;

    logic signed [15:0] sx, sy, sz;
    logic [33:0] p10;

    logic signed [24:0] d10, pred;
    logic               ceil_hit, floor_hit;
    logic signed [15:0] vz_f;
    res_t               res_next;

    assign advb     = ~vb_reg | out_ready;
    assign adva     = ~va_reg | advb;
    assign in_ready = adva;

    function automatic logic [15:0] apply_scale(input logic ov, input logic [15:0] v,
                                                input logic [14:0] q);
        begin
            if (!ov)
                apply_scale = v;
            else if (v[15])
                apply_scale = ~{1'b0, q} + 16'd1;
            else
                apply_scale = {1'b0, q};
        end
    endfunction

    always_comb
    begin
        sx  = apply_scale(in_data.ov, in_data.cmd.vx, in_data.qx);
        sy  = apply_scale(in_data.ov, in_data.cmd.vy, in_data.qy);
        sz  = apply_scale(in_data.ov, in_data.cmd.vz, in_data.qz);
        p10 = abs17(sz) * DIV10_MUL;
    end

    always_comb
    begin
        d10 = sz_reg[15] ? -$signed({13'd0, q10_reg}) : $signed({13'd0, q10_reg});
        pred = $signed({ca_reg.alt[23], ca_reg.alt}) + d10;
        ceil_hit  = pred > $signed({cfg.ceiling[23], cfg.ceiling});
        floor_hit = pred < $signed({cfg.floor_lim[23], cfg.floor_lim});
        vz_f = sz_reg;
        if (ceil_hit && vz_f > 16'sd0)
            vz_f = '0;
        if (floor_hit && vz_f < 16'sd0)
            vz_f = '0;

        res_next.mask = '0;
        if (cfg.estop)
        begin
            res_next.vx    = '0;
            res_next.vy    = '0;
            res_next.vz    = '0;
            res_next.yaw   = '0;
            res_next.roll  = ca_reg.roll;
            res_next.pitch = ca_reg.pitch;
            res_next.mask[VIO_ESTOP] = 1'b1;
        end
        else
        begin
            res_next.vx = sx_reg;
            res_next.vy = sy_reg;
            res_next.vz = vz_f;
            res_next.mask[VIO_SPEED]   = ova_reg;
            res_next.mask[VIO_YAW]     = exceeds(ca_reg.yaw, cfg.max_turn);
            res_next.mask[VIO_ROLL]    = exceeds(ca_reg.roll, cfg.max_tilt);
            res_next.mask[VIO_PITCH]   = exceeds(ca_reg.pitch, cfg.max_tilt);
            res_next.mask[VIO_CEILING] = ceil_hit;
            res_next.mask[VIO_FLOOR]   = floor_hit;
            res_next.yaw   = res_next.mask[VIO_YAW]
                           ? clamp_to(ca_reg.yaw, cfg.max_turn) : ca_reg.yaw;
            res_next.roll  = res_next.mask[VIO_ROLL]
                           ? clamp_to(ca_reg.roll, cfg.max_tilt) : ca_reg.roll;
            res_next.pitch = res_next.mask[VIO_PITCH]
                           ? clamp_to(ca_reg.pitch, cfg.max_tilt) : ca_reg.pitch;
        end
        res_next.safe = ~|res_next.mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (adva) va_reg <= in_valid;
            if (advb) vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adva)
        begin
            ca_reg  <= in_data.cmd;
            ova_reg <= in_data.ov;
            sx_reg  <= sx;
            sy_reg  <= sy;
            sz_reg  <= sz;
            q10_reg <= p10[DIV10_SHIFT+11:DIV10_SHIFT];
        end
        if (advb)
            res_reg <= res_next;
    end

    assign out_valid = vb_reg;
    assign out_data  = res_reg;

endmodule

// File: rtl/fcsl_checker.sv
// fcsl_checker: port-level assertions for the flight command limiter, bound to the top level
// depends on flight_command_safety_limiter_unit ports only
module fcsl_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    // output valid is cleared by the edge seen in reset
    a_reset_clears: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    // stalled output transaction keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output changed");

    // safe flag is exactly the absence of violations
    a_safe: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[103] == (m_tdata[102:96] == 7'd0)))
        else $error("cmd_safe disagrees with mask");

    // emergency stop zeroes velocities and yaw and is the only flag
    a_estop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[96] |-> (m_tdata[63:0] == 64'd0) && (m_tdata[102:97] == 6'd0))
        else $error("emergency stop result not zeroed");

endmodule

bind flight_command_safety_limiter_unit fcsl_checker u_fcsl_checker (.*);

// File: sim/flight_command_safety_limiter_unit_tb.sv
// flight_command_safety_limiter_unit_tb: self-checking bench for the flight command limiter
// depends on fcsl_pkg and flight_command_safety_limiter_unit; drives the stream ports with
// bursty traffic and a stalling receiver, and checks each result against a local predictor
`timescale 1ns / 100ps

module flight_command_safety_limiter_unit_tb;
    import fcsl_pkg::*;

    typedef struct {
        logic signed [15:0] vx, vy, vz, yaw, roll, pitch;
        logic signed [23:0] alt;
    } command_t;

    typedef struct {
        logic signed [15:0] vx, vy, vz, yaw, roll, pitch;
        logic [6:0]         mask;
        logic               safe;
    } limited_t;

    typedef struct {
        logic [14:0]        max_speed, max_turn, max_tilt;
        logic signed [23:0] ceiling, floor_lim;
        logic               estop;
    } limits_t;

    class limiter_scoreboard;
        limits_t  lim;
        limited_t pending[$];
        int       mismatches;
        int       checked;

        function new();
            lim.max_speed = MAX_SPEED_RST;
            lim.max_turn  = MAX_TURN_RST;
            lim.max_tilt  = MAX_TILT_RST;
            lim.ceiling   = CEILING_RST;
            lim.floor_lim = FLOOR_RST;
            lim.estop     = 1'b0;
            mismatches    = 0;
            checked       = 0;
        endfunction

        function void set_limit(cfg_idx_t idx, logic [23:0] val);
            case (idx)
                CFG_MAX_SPEED: lim.max_speed = val[14:0];
                CFG_MAX_TURN:  lim.max_turn  = val[14:0];
                CFG_MAX_TILT:  lim.max_tilt  = val[14:0];
                CFG_CEILING:   lim.ceiling   = val;
                CFG_FLOOR:     lim.floor_lim = val;
                CFG_ESTOP:     lim.estop     = val[0];
                default: ;
            endcase
        endfunction

        function longint root_floor(longint x);
            longint r;
            longint b;
            r = 0;
            for (b = 1 << 20; b > 0; b = b >> 1)
                if ((r + b) * (r + b) <= x)
                    r = r + b;
            return r;
        endfunction

        function longint clamp_axis(longint v, longint l, int bitpos, inout logic [6:0] m);
            longint a;
            a = v < 0 ? -v : v;
            if (a > l)
            begin
                m[bitpos] = 1'b1;
                return v < 0 ? -l : l;
            end
            return v;
        endfunction

        function void note_command(command_t c);
            limited_t e;
            longint vx, vy, vz, yaw, roll, pitch, mag, spd, pred;
            logic [6:0] m;
            m = '0;
            vx = c.vx; vy = c.vy; vz = c.vz;
            yaw = c.yaw; roll = c.roll; pitch = c.pitch;
            if (lim.estop)
            begin
                vx = 0; vy = 0; vz = 0; yaw = 0;
                m[VIO_ESTOP] = 1'b1;
            end
            else
            begin
                mag = root_floor(vx * vx + vy * vy + vz * vz);
                spd = lim.max_speed;
                if (mag > spd)
                begin
                    m[VIO_SPEED] = 1'b1;
                    vx = vx * spd / mag;
                    vy = vy * spd / mag;
                    vz = vz * spd / mag;
                end
                yaw   = clamp_axis(yaw, lim.max_turn, VIO_YAW, m);
                roll  = clamp_axis(roll, lim.max_tilt, VIO_ROLL, m);
                pitch = clamp_axis(pitch, lim.max_tilt, VIO_PITCH, m);
                pred = longint'(c.alt) + vz / 10;
                if (pred > longint'(lim.ceiling))
                begin
                    m[VIO_CEILING] = 1'b1;
                    if (vz > 0) vz = 0;
                end
                if (pred < longint'(lim.floor_lim))
                begin
                    m[VIO_FLOOR] = 1'b1;
                    if (vz < 0) vz = 0;
                end
            end
            e.vx = vx[15:0]; e.vy = vy[15:0]; e.vz = vz[15:0];
            e.yaw = yaw[15:0]; e.roll = roll[15:0]; e.pitch = pitch[15:0];
            e.mask = m;
            e.safe = (m == '0);
            pending.insert(pending.size(), e);
        endfunction

        function void check_result(logic [103:0] d);
            limited_t e;
            limited_t a;
            a.vx = d[15:0]; a.vy = d[31:16]; a.vz = d[47:32];
            a.yaw = d[63:48]; a.roll = d[79:64]; a.pitch = d[95:80];
            a.mask = d[102:96]; a.safe = d[103];
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %h", d);
                return;
            end
            e = pending.pop_front();
            if (a.vx !== e.vx || a.vy !== e.vy || a.vz !== e.vz || a.yaw !== e.yaw ||
                a.roll !== e.roll || a.pitch !== e.pitch || a.mask !== e.mask ||
                a.safe !== e.safe)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch #%0d exp v=%0d,%0d,%0d ypr=%0d,%0d,%0d m=%b s=%b",
                              " | got v=%0d,%0d,%0d ypr=%0d,%0d,%0d m=%b s=%b"},
                        checked, e.vx, e.vy, e.vz, e.yaw, e.roll, e.pitch, e.mask, e.safe,
                        a.vx, a.vy, a.vz, a.yaw, a.roll, a.pitch, a.mask, a.safe);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [23:0]  cfg_wdata;

    limiter_scoreboard limiter_sb;
    longint cycles;
    int     sent;
    int     stall_mode;

    localparam longint CYCLE_LIMIT = 400000;

    flight_command_safety_limiter_unit DUT (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // result side: sample at the rising edge, change ready at the falling edge
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            limiter_sb.check_result(m_tdata);

    always @(negedge clk)
    begin
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (cycles % 23) > 8;
        endcase
    end

    task automatic write_limit(cfg_idx_t idx, logic [23:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        limiter_sb.set_limit(idx, val);
    endtask

    task automatic drive_command(command_t c);
        s_tvalid <= 1'b1;
        s_tdata  <= {c.alt, c.pitch, c.roll, c.yaw, c.vz, c.vy, c.vx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        limiter_sb.note_command(c);
        sent++;
        @(negedge clk);
    endtask

    task automatic idle_cycles(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain;
        while (limiter_sb.pending.size() != 0)
            @(negedge clk);
        repeat (45) @(negedge clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return $urandom_range(0, 1) ? 16'($urandom_range(0, 600)) : -16'($urandom_range(0, 600));
            3: return 16'($urandom_range(0, 6000)) - 16'd3000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic command_t random_command(logic signed [23:0] ceil_v,
                                                logic signed [23:0] floor_v);
        command_t c;
        c.vx = pick16(); c.vy = pick16(); c.vz = pick16();
        c.yaw = pick16(); c.roll = pick16(); c.pitch = pick16();
        case ($urandom_range(0, 3))
            0: c.alt = ceil_v + 24'($urandom_range(0, 8000)) - 24'd4000;
            1: c.alt = floor_v + 24'($urandom_range(0, 8000)) - 24'd4000;
            2: c.alt = $urandom_range(0, 1) ? 24'h800000 : 24'h7fffff;
            default: c.alt = 24'($urandom());
        endcase
        return c;
    endfunction

    task automatic random_phase(int n);
        int left;
        int burst;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && left > 0)
            begin
                drive_command(random_command(limiter_sb.lim.ceiling, limiter_sb.lim.floor_lim));
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 8));
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic directed_phase;
        command_t c;
        c = '{0, 0, 0, 0, 0, 0, 0};
        drive_command(c);
        c = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 24'h7fffff};
        drive_command(c);
        c = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 24'h800000};
        drive_command(c);
        c = '{100, -200, 300, 4096, -2145, 2145, 1000};
        drive_command(c);
        c = '{0, 0, 2000, 4097, 2146, -2146, 30700};
        drive_command(c);
        c = '{0, 0, -2000, 0, 0, 0, 50};
        drive_command(c);
        c = '{1500, 1500, 1500, -4097, 0, 0, 30720};
        drive_command(c);
        c = '{-3000, 0, 0, 0, 0, 0, 0};
        drive_command(c);
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        limiter_sb = new();
        cycles     = 0;
        sent       = 0;
        stall_mode = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b1;
        cfg_we     = 1'b0;
        cfg_addr   = CFG_MAX_SPEED;
        cfg_wdata  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset limits first
        directed_phase();
        drain();

        // estop with extremes on roll and pitch passing through
        write_limit(CFG_ESTOP, 24'd1);
        stall_mode = 1;
        directed_phase();
        random_phase(40);
        drain();
        write_limit(CFG_ESTOP, 24'd0);

        // zero limits everywhere, floor above ceiling
        write_limit(CFG_MAX_SPEED, 24'd0);
        write_limit(CFG_MAX_TURN, 24'd0);
        write_limit(CFG_MAX_TILT, 24'd0);
        write_limit(CFG_CEILING, 24'hffff00);
        write_limit(CFG_FLOOR, 24'd256);
        stall_mode = 2;
        directed_phase();
        random_phase(120);
        drain();

        // widest limits and extreme altitudes
        write_limit(CFG_MAX_SPEED, 24'h7fff);
        write_limit(CFG_MAX_TURN, 24'h7fff);
        write_limit(CFG_MAX_TILT, 24'h7fff);
        write_limit(CFG_CEILING, 24'h7fffff);
        write_limit(CFG_FLOOR, 24'h800000);
        stall_mode = 3;
        random_phase(150);
        drain();

        // random limit settings across the full range
        repeat (4)
        begin
            write_limit(CFG_MAX_SPEED, 24'($urandom_range(0, 32767)));
            write_limit(CFG_MAX_TURN, 24'($urandom_range(0, 32767)));
            write_limit(CFG_MAX_TILT, 24'($urandom_range(0, 32767)));
            write_limit(CFG_CEILING, 24'($urandom()));
            write_limit(CFG_FLOOR, 24'($urandom()));
            stall_mode = $urandom_range(0, 3);
            random_phase(150);
            drain();
        end

        $display("sent %0d commands over reset, estop, zero, widest and random limit sets",
            sent);
        $display("checked %0d results, %0d mismatches", limiter_sb.checked,
            limiter_sb.mismatches);
        if (limiter_sb.mismatches == 0 && limiter_sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
